/* rtl/arc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the address resolution cache.
package arc_pkg;

  localparam int ENTRIES_DEFAULT = 256;
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int WORD_W = IP_W + MAC_W;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_LEARN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } arc_state_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             send_request;
  } arc_result_t;

endpackage

/* rtl/arp_resolution_cache.sv */
`timescale 1ns / 1ps
// Address resolution cache top level: table memory, sequencer and output register.
// A learn word goes through ST_DONE to the output register; a lookup first scans the table
// in ST_SCAN until a hit or the last filled entry, or goes straight to ST_DONE if empty.
// One word at a time: in_stall holds new words off until the output register takes the
// result, and the linear scan reads one table entry per cycle from the single read port.
// Reset clears the write pointer and fill count at once, so no clearing pass is needed.
module arp_resolution_cache import arc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [IP_W-1:0]  ip_addr,
  input  logic [MAC_W-1:0] mac_addr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             hit,
  output logic [MAC_W-1:0] found_mac,
  output logic             send_request
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  arc_result_t       res;
  logic              res_take;

  // The result moves into the output register whenever that register is
  // empty or being drained, which frees the sequencer for the next word.
  assign res_take = res_valid && (!out_valid || !out_stall);

  arc_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  arc_scan #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .CW      (CW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item_kind  (kind),
    .item_ip    (ip_addr),
    .item_mac   (mac_addr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      hit          <= res.hit;
      found_mac    <= res.found_mac;
      send_request <= res.send_request;
    end
  end

endmodule

/* rtl/arc_mem.sv */
`timescale 1ns / 1ps
// Single-port-write, single-port-read table memory with registered read data.
module arc_mem import arc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  parameter int AW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/arc_scan.sv */
`timescale 1ns / 1ps
// Learn and lookup sequencer: write pointer, fill count and the linear table scan.
module arc_scan import arc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  parameter int AW = $clog2(ENTRIES),
  parameter int CW = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              item_kind,
  input  logic [IP_W-1:0]   item_ip,
  input  logic [MAC_W-1:0]  item_mac,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [WORD_W-1:0] mem_rdata,
  output logic              res_valid,
  output arc_result_t       res,
  input  logic              res_take
);

  arc_state_t  state, state_next;
  logic [AW-1:0]   wp, wp_next;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   cmp_idx;
  logic [IP_W-1:0] key;
  arc_result_t     res_next;
  logic            learn;
  logic            last_entry;
  logic            match;

  // Entries fill in order from 0, so entry i holds a valid pair exactly when
  // i is below the fill count; no per-entry valid flags are needed.
  assign last_entry = ((CW'(cmp_idx) + CW'(1)) == fill);
  assign match      = (mem_rdata[WORD_W-1:MAC_W] == key);
  assign wp_next    = (wp == AW'(ENTRIES - 1)) ? '0 : wp + AW'(1);
  assign mem_waddr  = wp;
  assign mem_wdata  = {item_ip, item_mac};
  assign res_valid  = (state == ST_DONE);

  always_comb begin
    state_next = state;
    item_stall = (state != ST_IDLE);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    learn      = 1'b0;
    res_next   = res;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_kind == KIND_LEARN) begin
            mem_we     = 1'b1;
            learn      = 1'b1;
            res_next   = '{hit: 1'b0, found_mac: '0, send_request: 1'b0};
            state_next = ST_DONE;
          end else if (fill == '0) begin
            res_next   = '{hit: 1'b0, found_mac: '0, send_request: 1'b1};
            state_next = ST_DONE;
          end else begin
            mem_re     = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // The word for cmp_idx is on the read port; the next read goes out
        // in the same cycle so the scan covers one entry per cycle.
        if (match) begin
          res_next   = '{hit: 1'b1, found_mac: mem_rdata[MAC_W-1:0], send_request: 1'b0};
          state_next = ST_DONE;
        end else if (last_entry) begin
          res_next   = '{hit: 1'b0, found_mac: '0, send_request: 1'b1};
          state_next = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cmp_idx + AW'(1);
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (learn) begin
        wp <= wp_next;
        if (fill != CW'(ENTRIES)) begin
          fill <= fill + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      cmp_idx <= mem_raddr;
    end
    if (state == ST_IDLE && item_valid) begin
      key <= item_ip;
    end
    res <= res_next;
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> fill != '0)
    else $error("scan running on an empty table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CW'(cmp_idx) < fill)
    else $error("scan compared an entry beyond the fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(ENTRIES))
    else $error("fill count exceeds table depth");

  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.hit && res.send_request))
    else $error("result reports both hit and request");

  a_learn_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && item_valid && item_kind == KIND_LEARN) |=>
      (state == ST_DONE && !res.hit && !res.send_request && res.found_mac == '0))
    else $error("learn did not produce an empty result");

endmodule
